// ----- rtl/bwt_pkg.sv -----
// Shared types and constants for the bone world transform block.
// Used by bwt_front, bwt_back and bone_world_transform; depends on nothing else.
package bwt_pkg;

    localparam int WORD_W      = 32;
    localparam int ROW_WORDS   = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef enum logic [1:0] {
        KIND_ROOT  = 2'd0,
        KIND_NULL  = 2'd1,
        KIND_CHILD = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0]                            bone;
        logic [8:0]                            parent;
        logic [1:0]                            row;
        t_kind                                 kind;
        logic                                  wr_en;
        logic [ROW_WORDS-1:0][WORD_W-1:0]      local_row;
    } t_item;

    typedef struct packed {
        t_item      item;
        logic [1:0] k;
        logic       first;
        logic       last;
    } t_beat;

endpackage

// ----- rtl/bwt_front.sv -----
// Input side of the bone world transform: accepts items, classifies the parent
// and holds them in a short queue for the back end. Depends on bwt_pkg.
module bwt_front
    import bwt_pkg::*;
#(
    parameter int MAX_BONES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_bone_index,
    input  logic signed [8:0]  i_parent_index,
    input  logic [1:0]         i_row_index,
    input  logic signed [31:0] i_local_c0,
    input  logic signed [31:0] i_local_c1,
    input  logic signed [31:0] i_local_c2,
    input  logic signed [31:0] i_local_c3,
    input  logic               i_clearing,
    output logic               o_q_valid,
    output t_item              o_q_item,
    input  logic               i_q_pop
);

    t_item             n_item;
    t_item             r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              push;

    always_comb begin
        n_item.bone      = i_bone_index;
        n_item.parent    = i_parent_index;
        n_item.row       = i_row_index;
        n_item.local_row = {i_local_c3, i_local_c2, i_local_c1, i_local_c0};
        n_item.wr_en     = 32'(i_bone_index) < 32'(MAX_BONES);
        if (i_parent_index[8]) begin
            n_item.kind = KIND_ROOT;
        end else if (32'(i_parent_index[7:0]) >= 32'(MAX_BONES)) begin
            n_item.kind = KIND_NULL;
        end else begin
            n_item.kind = KIND_CHILD;
        end
    end

    assign o_in_ready = !i_clearing && (r_count != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign push       = i_in_valid && o_in_ready;
    assign o_q_valid  = r_count != '0;
    assign o_q_item   = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, i_q_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/bwt_back.sv -----
// Execution side of the bone world transform: world matrix store, row reads,
// four multipliers, accumulation, saturation and the result register.
// Depends on bwt_pkg.
module bwt_back
    import bwt_pkg::*;
#(
    parameter int MAX_BONES = 256,
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_item              i_q_item,
    output logic               o_q_pop,
    output logic               o_clearing,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_out_bone,
    output logic [1:0]         o_out_row,
    output logic signed [31:0] o_world_c0,
    output logic signed [31:0] o_world_c1,
    output logic signed [31:0] o_world_c2,
    output logic signed [31:0] o_world_c3
);

    localparam int BONE_W = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
    localparam int ADDR_W = BONE_W + 2;
    localparam int DEPTH  = MAX_BONES * ROW_WORDS;
    localparam int PROD_W = 2 * WORD_W;
    localparam int TERM_W = PROD_W - FRAC_BITS;
    localparam int ACC_W  = TERM_W + 2;
    localparam int HI_W   = ACC_W - WORD_W + 1;

    localparam logic [WORD_W-1:0] SAT_POS = {1'b0, {(WORD_W - 1){1'b1}}};
    localparam logic [WORD_W-1:0] SAT_NEG = {1'b1, {(WORD_W - 1){1'b0}}};

    logic [ROW_WORDS-1:0][WORD_W-1:0] r_mem [DEPTH];
    logic [ROW_WORDS-1:0][WORD_W-1:0] r_rdata;
    logic                             r_clearing;
    logic [ADDR_W-1:0]                r_clr_addr;
    logic [1:0]                       r_k;
    logic                             r_b_valid;
    t_beat                            r_b;
    logic                             r_c_valid;
    t_beat                            r_c;
    logic signed [PROD_W-1:0]         r_prod [ROW_WORDS];
    logic signed [ACC_W-1:0]          r_acc [ROW_WORDS];
    logic                             r_out_valid;
    logic [7:0]                       r_out_bone;
    logic [1:0]                       r_out_row;
    logic [ROW_WORDS-1:0][WORD_W-1:0] r_out_row_data;

    logic                             is_child;
    logic                             last_beat;
    logic                             hazard;
    logic                             adv;
    logic                             issue;
    logic                             load;
    logic [BONE_W-1:0]                parent_sel;
    logic [ADDR_W-1:0]                rd_addr;
    t_beat                            beat;
    logic                             mem_we;
    logic [ADDR_W-1:0]                mem_waddr;
    logic [ROW_WORDS-1:0][WORD_W-1:0] mem_wdata;
    logic signed [TERM_W-1:0]         term [ROW_WORDS];
    logic signed [ACC_W-1:0]          base [ROW_WORDS];
    logic signed [ACC_W-1:0]          acc_n [ROW_WORDS];
    logic [HI_W-1:0]                  hi [ROW_WORDS];
    logic [ROW_WORDS-1:0][WORD_W-1:0] sat_row;
    logic [ROW_WORDS-1:0][WORD_W-1:0] world_row;

    // A child reads its parent's four rows, one per cycle while not stalled; other items take one beat.
    // Only a last beat still in flight marks a row that has not yet been written.
    assign is_child   = i_q_item.kind == KIND_CHILD;
    assign last_beat  = !is_child || (r_k == 2'd3);
    assign parent_sel = BONE_W'(i_q_item.parent[7:0]);
    assign hazard     = is_child &&
                        ((r_b_valid && r_b.last && (r_b.item.bone == i_q_item.parent[7:0])) ||
                         (r_c_valid && r_c.last && (r_c.item.bone == i_q_item.parent[7:0])));
    assign adv        = !(r_c_valid && r_c.last && r_out_valid && !i_out_ready);
    assign issue      = adv && i_q_valid && !hazard && !r_clearing;
    assign o_q_pop    = issue && last_beat;
    assign o_clearing = r_clearing;
    assign rd_addr    = is_child ? {parent_sel, r_k} : '0;
    assign load       = adv && r_c_valid && r_c.last;

    always_comb begin
        beat.item  = i_q_item;
        beat.k     = r_k;
        beat.first = r_k == 2'd0;
        beat.last  = last_beat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    assign mem_we    = r_clearing || (load && r_c.item.wr_en);
    assign mem_waddr = r_clearing ? r_clr_addr : {BONE_W'(r_c.item.bone), r_c.item.row};
    assign mem_wdata = r_clearing ? '0 : world_row;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (adv) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k       <= '0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (issue) begin
                r_k <= last_beat ? 2'd0 : r_k + 2'd1;
            end
            if (adv) begin
                r_b_valid <= issue;
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b <= beat;
            r_c <= r_b;
            for (int c = 0; c < ROW_WORDS; c++) begin
                r_prod[c] <= $signed(r_b.item.local_row[r_b.k]) * $signed(r_rdata[c]);
            end
        end
        if (adv && r_c_valid) begin
            for (int c = 0; c < ROW_WORDS; c++) begin
                r_acc[c] <= acc_n[c];
            end
        end
    end

    // Dropping the fraction bits of each product rounds toward minus infinity.
    always_comb begin
        for (int c = 0; c < ROW_WORDS; c++) begin
            term[c] = r_prod[c][PROD_W-1:FRAC_BITS];
            if (r_c.first) begin
                base[c] = '0;
            end else begin
                base[c] = r_acc[c];
            end
            acc_n[c] = base[c] + ACC_W'(term[c]);
            hi[c]    = acc_n[c][ACC_W-1:WORD_W-1];
            if (hi[c] == '0 || hi[c] == '1) begin
                sat_row[c] = acc_n[c][WORD_W-1:0];
            end else if (acc_n[c][ACC_W-1]) begin
                sat_row[c] = SAT_NEG;
            end else begin
                sat_row[c] = SAT_POS;
            end
        end
    end

    always_comb begin
        unique case (r_c.item.kind)
            KIND_ROOT:  world_row = r_c.item.local_row;
            KIND_NULL:  world_row = '0;
            KIND_CHILD: world_row = sat_row;
            default:    world_row = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_bone     <= r_c.item.bone;
            r_out_row      <= r_c.item.row;
            r_out_row_data <= world_row;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_bone  = r_out_bone;
    assign o_out_row   = r_out_row;
    assign o_world_c0  = r_out_row_data[0];
    assign o_world_c1  = r_out_row_data[1];
    assign o_world_c2  = r_out_row_data[2];
    assign o_world_c3  = r_out_row_data[3];

endmodule

// ----- rtl/bone_world_transform.sv -----
// Bone world transform: a child row reads its parent's four rows, one per cycle
// unless the back end stalls, from the single read port of the world store; a root
// row or a row with an out-of-range parent needs no parent row. The result is
// registered, and a child waits while its parent is still being written. After reset
// a clearing pass over all MAX_BONES*4 store rows zeroes the store, and no item is
// accepted until it ends.
module bone_world_transform
    import bwt_pkg::*;
#(
    parameter int MAX_BONES = 256,
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_bone_index,
    input  logic signed [8:0]  i_parent_index,
    input  logic [1:0]         i_row_index,
    input  logic signed [31:0] i_local_c0,
    input  logic signed [31:0] i_local_c1,
    input  logic signed [31:0] i_local_c2,
    input  logic signed [31:0] i_local_c3,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_out_bone,
    output logic [1:0]         o_out_row,
    output logic signed [31:0] o_world_c0,
    output logic signed [31:0] o_world_c1,
    output logic signed [31:0] o_world_c2,
    output logic signed [31:0] o_world_c3
);

    logic  q_valid;
    t_item q_item;
    logic  q_pop;
    logic  clearing;

    bwt_front #(
        .MAX_BONES(MAX_BONES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_bone_index   (i_bone_index),
        .i_parent_index (i_parent_index),
        .i_row_index    (i_row_index),
        .i_local_c0     (i_local_c0),
        .i_local_c1     (i_local_c1),
        .i_local_c2     (i_local_c2),
        .i_local_c3     (i_local_c3),
        .i_clearing     (clearing),
        .o_q_valid      (q_valid),
        .o_q_item       (q_item),
        .i_q_pop        (q_pop)
    );

    bwt_back #(
        .MAX_BONES(MAX_BONES),
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_bone  (o_out_bone),
        .o_out_row   (o_out_row),
        .o_world_c0  (o_world_c0),
        .o_world_c1  (o_world_c1),
        .o_world_c2  (o_world_c2),
        .o_world_c3  (o_world_c3)
    );

endmodule

// ----- rtl/bwt_checker.sv -----
// Port-level checks for the bone world transform, attached by a bind below.
// Depends only on the ports of bone_world_transform.
module bwt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_out_bone,
    input logic [1:0]  o_out_row,
    input logic [31:0] o_world_c0,
    input logic [31:0] o_world_c1,
    input logic [31:0] o_world_c2,
    input logic [31:0] o_world_c3
);

    logic [3:0] r_pending;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            case ({in_acc, out_acc})
                2'b10:   r_pending <= r_pending + 1'b1;
                2'b01:   r_pending <= r_pending - 1'b1;
                default: r_pending <= r_pending;
            endcase
        end
    end

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_in_ready)
        else $error("item accepted while the store is being cleared");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_bone) &&
        $stable(o_out_row) && $stable(o_world_c0) && $stable(o_world_c1) &&
        $stable(o_world_c2) && $stable(o_world_c3))
        else $error("stalled result changed");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pending != '0)
        else $error("result given without an item in flight");

endmodule

bind bone_world_transform bwt_checker u_bwt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_bone  (o_out_bone),
    .o_out_row   (o_out_row),
    .o_world_c0  (o_world_c0),
    .o_world_c1  (o_world_c1),
    .o_world_c2  (o_world_c2),
    .o_world_c3  (o_world_c3)
);

// ----- tb/bone_world_transform_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for bone_world_transform: queued bone rows are driven through
// a valid/ready driver, and each world row is checked against an in-bench Q16.16 model.
// Depends on the RTL top level bone_world_transform and its package bwt_pkg.
module bone_world_transform_tb;

    localparam int MAX_BONES   = 256;
    localparam int FRAC_BITS   = 16;
    localparam int TOTAL_ROWS  = 1150;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 20;
    localparam int IDLE_PCT    = 34;
    localparam logic signed [8:0] ROOT_PARENT = -9'sd1;
    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [7:0]        bone;
        logic signed [8:0] parent;
        logic [1:0]        row;
        logic [3:0][31:0]  col;
    } t_bone_row;

    typedef struct packed {
        logic [7:0]       bone;
        logic [1:0]       row;
        logic [3:0][31:0] col;
    } t_world_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [7:0]         i_bone_index = '0;
    logic signed [8:0]  i_parent_index = '0;
    logic [1:0]         i_row_index = '0;
    logic signed [31:0] i_local_c0 = '0;
    logic signed [31:0] i_local_c1 = '0;
    logic signed [31:0] i_local_c2 = '0;
    logic signed [31:0] i_local_c3 = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [7:0]         o_out_bone;
    logic [1:0]         o_out_row;
    logic signed [31:0] o_world_c0;
    logic signed [31:0] o_world_c1;
    logic signed [31:0] o_world_c2;
    logic signed [31:0] o_world_c3;

    t_bone_row   pending_rows[$];
    t_world_row  awaited_rows[$];
    t_bone_row   driven_row;
    logic signed [31:0] world_mem [MAX_BONES][4][4];
    logic [31:0] edge_words [6] = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000,
                                    32'h0001_0000, 32'hffff_0000, 32'hffff_ffff};

    int unsigned cycle_count = 0;
    int unsigned rows_sent = 0;
    int unsigned rows_checked = 0;
    int unsigned error_count = 0;
    int unsigned root_rows = 0;
    int unsigned child_rows = 0;
    int unsigned saturated_words = 0;

    bone_world_transform #(
        .MAX_BONES(MAX_BONES),
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_bone_index(i_bone_index),
        .i_parent_index(i_parent_index),
        .i_row_index(i_row_index),
        .i_local_c0(i_local_c0),
        .i_local_c1(i_local_c1),
        .i_local_c2(i_local_c2),
        .i_local_c3(i_local_c3),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_bone(o_out_bone),
        .o_out_row(o_out_row),
        .o_world_c0(o_world_c0),
        .o_world_c1(o_world_c1),
        .o_world_c2(o_world_c2),
        .o_world_c3(o_world_c3)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // World row of one bone row: a root row keeps its local row, else the local row times
    // the parent's stored matrix, each product floored to Q16.16, summed exactly and saturated to 32 bits.
    function automatic t_world_row transform_row(input t_bone_row item);
        t_world_row   res;
        longint       acc;
        longint       prod;
        logic [7:0]   par;
        res.bone = item.bone;
        res.row  = item.row;
        par      = item.parent[7:0];
        for (int c = 0; c < 4; c++) begin
            if (item.parent < 0) begin
                res.col[c] = item.col[c];
            end else begin
                acc = 0;
                for (int k = 0; k < 4; k++) begin
                    prod = longint'($signed(item.col[k])) * longint'(world_mem[par][k][c]);
                    acc += prod >>> FRAC_BITS;
                end
                if (acc > WORD_MAX) begin
                    res.col[c] = 32'h7fff_ffff;
                    saturated_words++;
                end else if (acc < WORD_MIN) begin
                    res.col[c] = 32'h8000_0000;
                    saturated_words++;
                end else begin
                    res.col[c] = acc[31:0];
                end
            end
        end
        if (item.parent < 0) begin
            root_rows++;
        end else begin
            child_rows++;
        end
        for (int c = 0; c < 4; c++) begin
            world_mem[item.bone][item.row][c] = res.col[c];
        end
        return res;
    endfunction

    function automatic logic [31:0] rand_word();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
        end else if (pick < 70) begin
            return edge_words[$urandom_range(0, 5)];
        end
        return $urandom();
    endfunction

    task automatic add_row(input logic [7:0] bone, input logic signed [8:0] parent,
                           input logic [1:0] row, input logic [31:0] c0, input logic [31:0] c1,
                           input logic [31:0] c2, input logic [31:0] c3);
        t_bone_row item;
        item.bone   = bone;
        item.parent = parent;
        item.row    = row;
        item.col    = {c3, c2, c1, c0};
        pending_rows.insert(pending_rows.size(), item);
    endtask

    // A small skeleton in parent-first order, every bone sending all four rows.
    task automatic add_skeleton();
        logic [7:0]        ids [12];
        logic signed [8:0] parent;
        int                count;
        count = $urandom_range(2, 12);
        for (int i = 0; i < count; i++) begin
            ids[i] = 8'($urandom_range(0, MAX_BONES - 1));
            if (i == 0 || $urandom_range(0, 3) == 0) begin
                parent = ROOT_PARENT;
            end else begin
                parent = {1'b0, ids[$urandom_range(0, i - 1)]};
            end
            for (int r = 0; r < 4; r++) begin
                add_row(ids[i], parent, 2'(r),
                        rand_word(), rand_word(), rand_word(), rand_word());
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                awaited_rows.insert(awaited_rows.size(), transform_row(driven_row));
                rows_sent++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_rows.size() > 0 && ((rows_sent >= 300 && rows_sent < 500) ||
                        $urandom_range(0, 99) >= IDLE_PCT)) begin
                    driven_row = pending_rows.pop_front();
                    i_bone_index   <= driven_row.bone;
                    i_parent_index <= driven_row.parent;
                    i_row_index    <= driven_row.row;
                    i_local_c0     <= driven_row.col[0];
                    i_local_c1     <= driven_row.col[1];
                    i_local_c2     <= driven_row.col[2];
                    i_local_c3     <= driven_row.col[3];
                    i_in_valid     <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_world_row got;
        t_world_row want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got.bone = o_out_bone;
                got.row  = o_out_row;
                got.col  = {o_world_c3, o_world_c2, o_world_c1, o_world_c0};
                if (awaited_rows.size() == 0) begin
                    $display("%0t: unexpected result bone %0d row %0d", $time, got.bone, got.row);
                    error_count++;
                end else begin
                    want = awaited_rows.pop_front();
                    if (got.bone != want.bone) begin
                        $display("%0t: bone mismatch, expected %0d, actual %0d",
                                 $time, want.bone, got.bone);
                        error_count++;
                    end
                    if (got.row != want.row) begin
                        $display("%0t: row mismatch, expected %0d, actual %0d",
                                 $time, want.row, got.row);
                        error_count++;
                    end
                    for (int c = 0; c < 4; c++) begin
                        if (got.col[c] != want.col[c]) begin
                            $display({"%0t: world_c%0d mismatch (bone %0d row %0d), ",
                                      "expected %h, actual %h"},
                                     $time, c, want.bone, want.row, want.col[c], got.col[c]);
                            error_count++;
                        end
                    end
                end
                rows_checked++;
            end
            i_out_ready <= (rows_checked >= 600 && rows_checked < 800) ||
                           $urandom_range(0, 99) >= IDLE_PCT;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(negedge i_clk);
        $display("timeout after %0d cycles with %0d results outstanding",
                 cycle_count, awaited_rows.size());
        $display("bone_world_transform_tb failed");
        $finish;
    end

    initial begin
        for (int b = 0; b < MAX_BONES; b++) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    world_mem[b][r][c] = '0;
                end
            end
        end

        // Root rows carrying the extreme words, then a child that saturates both ways.
        add_row(8'd0, ROOT_PARENT, 2'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h1);
        add_row(8'd0, ROOT_PARENT, 2'd1, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h1_0000);
        add_row(8'd0, ROOT_PARENT, 2'd2, 32'h1_0000, 32'h0, 32'h7fff_ffff, 32'h8000_0000);
        add_row(8'd0, ROOT_PARENT, 2'd3, 32'h0, 32'h1_0000, 32'h8000_0000, 32'h7fff_ffff);
        add_row(8'd1, 9'sd0, 2'd0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        add_row(8'd1, 9'sd0, 2'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_row(8'd1, 9'sd0, 2'd2, 32'hffff_ffff, 32'h1, 32'h0, 32'hffff_ffff);
        add_row(8'd1, 9'sd0, 2'd3, 32'h1_0000, 32'hffff_0000, 32'h8000, 32'hffff_8000);
        // A bone that is its own parent reads its old matrix.
        add_row(8'd1, 9'sd1, 2'd2, 32'h1_0000, 32'h2_0000, 32'hffff_0000, 32'h0);
        // The most negative parent index is still a root.
        add_row(8'd2, -9'sd256, 2'd1, 32'h1234_5678, 32'h8765_4321, 32'hffff_ffff, 32'h0);
        // Parents never written read as zero.
        add_row(8'd3, 9'sd200, 2'd0, 32'h7fff_ffff, 32'h1_0000, 32'h8000_0000, 32'h5555_5555);
        add_row(8'd255, 9'sd255, 2'd3, 32'haaaa_aaaa, 32'h5555_5555, 32'h1, 32'hffff_ffff);
        add_row(8'd255, ROOT_PARENT, 2'd0, 32'h1_0000, 32'h2_8000, 32'hfffe_0000, 32'h7fff_ffff);
        add_row(8'd255, ROOT_PARENT, 2'd1, 32'h0, 32'h1_0000, 32'h0, 32'h0);
        add_row(8'd255, ROOT_PARENT, 2'd2, 32'h0, 32'h0, 32'h1_0000, 32'h0);
        add_row(8'd4, 9'sd255, 2'd0, 32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000);
        add_row(8'd4, 9'sd255, 2'd1, 32'hffff_ffff, 32'h8000_0000, 32'h0, 32'h7fff_ffff);

        while (pending_rows.size() < TOTAL_ROWS) begin
            if ($urandom_range(0, 9) < 8) begin
                add_skeleton();
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    add_row(8'($urandom()), 9'($urandom()), 2'($urandom()),
                            $urandom(), $urandom(), $urandom(), $urandom());
                end
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_rows.size() != 0 || i_in_valid) @(negedge i_clk);
        while (awaited_rows.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        $display("Sent %0d rows (%0d root, %0d child) and checked %0d results.",
                 rows_sent, root_rows, child_rows, rows_checked);
        $display("%0d world words saturated; %0d mismatches.", saturated_words, error_count);
        if (error_count == 0) begin
            $display("bone_world_transform_tb passed");
        end else begin
            $display("bone_world_transform_tb failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/bwt_pkg.sv
rtl/bwt_front.sv
rtl/bwt_back.sv
rtl/bone_world_transform.sv
rtl/bwt_checker.sv
tb/bone_world_transform_tb.sv
